### design/fpba_pkg.sv
package fpba_pkg;

  localparam int SIZE_W = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  localparam logic [1:0] POL_BEST = 2'd0;
  localparam logic [1:0] POL_FIRST = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;
  localparam logic [1:0] POL_NONE = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION = 2'd1;

  localparam logic [1:0] CMD_NOP = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_MERGE = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [15:0] request_size;
    logic [15:0] payload_address;
  } req_t;

  typedef struct packed {
    logic [15:0] granted_address;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    logic [1:0] op;
    logic       split;
    logic       merge;
    logic       clr;
  } cell_ctl_t;

endpackage

### design/fit_policy_block_allocator_unit.sv
// Block allocator over one byte region, kept as an address-ordered row of
// MAX_BLOCKS cells, each holding one block (start, payload size, busy mark).
// Requests are allocate (best, first or worst fit per fit_policy, or no fit at
// all for POL_NONE; size rounded up to 4, split when a header plus 4 bytes
// remain) and free (with merging of free neighbors). One request at a time:
// a transaction runs a search that walks the cell chain one cell per cycle,
// followed by a table update for any request that succeeds and a further
// update for a previous-neighbor merge. A failed request skips the update.
// A write to REG_REGION restarts the table as one free block at once.
module fit_policy_block_allocator_unit #(
  parameter int MAX_BLOCKS = 64,
  parameter int ADDRESS_BITS = 16,
  parameter int HEADER_BYTES = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  fpba_pkg::req_t                    req,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output fpba_pkg::rsp_t                    rsp,
  input  logic                              cfg_we,
  input  logic [fpba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fpba_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int M = MAX_BLOCKS;
  localparam int AW = ADDRESS_BITS;
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int NW = $clog2(MAX_BLOCKS + 1);
  localparam int CW = (AW > 17 ? AW : 17) + 1;
  localparam logic [33:0] LIM = 34'(1) << AW;
  localparam logic [33:0] MINR = 34'(HEADER_BYTES + 4);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_APPLY = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  function automatic logic [AW-1:0] region_pay(input logic [16:0] v);
    logic [33:0] r;
    r = 34'(v);
    if (r > LIM) r = LIM;
    if (r < MINR) r = MINR;
    region_pay = AW'((r - 34'(HEADER_BYTES)) & ~34'd3);
  endfunction

  logic [2:0]                  state;
  logic [IW-1:0]               cnt;
  logic                        op_q;
  logic [fpba_pkg::SIZE_W-1:0] size_q;
  logic                        zero_q;
  logic [15:0]                 addr_q;
  logic [1:0]                  policy;
  fpba_pkg::cell_ctl_t         ctl;
  logic [IW-1:0]               cmd_idx;
  logic [NW-1:0]               count;
  logic                        pend_prev;
  fpba_pkg::rsp_t              res_q;

  logic          init;
  logic [AW-1:0] init_pay;

  logic          ent_valid [M];
  logic          ent_busy  [M];
  logic [AW-1:0] ent_start [M];
  logic [AW-1:0] ent_pay   [M];
  logic          sc_found  [M];
  logic [IW-1:0] sc_idx    [M];
  logic [AW-1:0] sc_pay    [M];
  logic [AW-1:0] sc_start  [M];
  logic          sc_busy   [M];
  logic          sc_prev   [M];
  logic          sc_next   [M];

  logic [CW-1:0] rem;
  logic          split;

  assign init = rst || (cfg_we && cfg_index == fpba_pkg::REG_REGION);
  assign init_pay = rst ? region_pay(17'h10000) : region_pay(cfg_data);
  assign req_ready = state == S_IDLE;

  genvar k;
  generate
    for (k = 0; k < M; k++) begin : g_cell
      logic          l_valid, l_busy, r_valid, r_busy;
      logic [AW-1:0] l_start, l_pay, r_start, r_pay;
      logic          i_found, i_busy, i_prev, i_next;
      logic [IW-1:0] i_idx;
      logic [AW-1:0] i_pay, i_start;

      if (k == 0) begin : g_first
        assign l_valid = 1'b0;
        assign l_busy = 1'b0;
        assign l_start = '0;
        assign l_pay = '0;
        assign i_found = 1'b0;
        assign i_idx = '0;
        assign i_pay = '0;
        assign i_start = '0;
        assign i_busy = 1'b0;
        assign i_prev = 1'b0;
        assign i_next = 1'b0;
      end else begin : g_mid
        assign l_valid = ent_valid[k-1];
        assign l_busy = ent_busy[k-1];
        assign l_start = ent_start[k-1];
        assign l_pay = ent_pay[k-1];
        assign i_found = sc_found[k-1];
        assign i_idx = sc_idx[k-1];
        assign i_pay = sc_pay[k-1];
        assign i_start = sc_start[k-1];
        assign i_busy = sc_busy[k-1];
        assign i_prev = sc_prev[k-1];
        assign i_next = sc_next[k-1];
      end

      if (k == M - 1) begin : g_last
        assign r_valid = 1'b0;
        assign r_busy = 1'b0;
        assign r_start = '0;
        assign r_pay = '0;
      end else begin : g_inner
        assign r_valid = ent_valid[k+1];
        assign r_busy = ent_busy[k+1];
        assign r_start = ent_start[k+1];
        assign r_pay = ent_pay[k+1];
      end

      fpba_cell #(
        .AW(AW),
        .IW(IW),
        .HB(HEADER_BYTES),
        .K(k)
      ) u_cell (
        .clk(clk),
        .rst(rst),
        .init(init),
        .init_pay(init_pay),
        .ctl(ctl),
        .cmd_idx(cmd_idx),
        .size(size_q),
        .scan_free(op_q),
        .policy(policy),
        .addr(addr_q),
        .lft_valid(l_valid),
        .lft_busy(l_busy),
        .lft_start(l_start),
        .lft_pay(l_pay),
        .rgt_valid(r_valid),
        .rgt_busy(r_busy),
        .rgt_start(r_start),
        .rgt_pay(r_pay),
        .valid(ent_valid[k]),
        .busy(ent_busy[k]),
        .start(ent_start[k]),
        .pay(ent_pay[k]),
        .si_found(i_found),
        .si_idx(i_idx),
        .si_pay(i_pay),
        .si_start(i_start),
        .si_busy(i_busy),
        .si_prev(i_prev),
        .si_next(i_next),
        .so_found(sc_found[k]),
        .so_idx(sc_idx[k]),
        .so_pay(sc_pay[k]),
        .so_start(sc_start[k]),
        .so_busy(sc_busy[k]),
        .so_prev(sc_prev[k]),
        .so_next(sc_next[k])
      );
    end
  endgenerate

  assign rem = CW'(sc_pay[M-1]) - CW'(size_q);
  assign split = rem >= CW'(HEADER_BYTES + 4);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      ctl <= '0;
      count <= NW'(1);
      pend_prev <= 1'b0;
      rsp_valid <= 1'b0;
      policy <= fpba_pkg::POL_BEST;
    end else begin
      if (rsp_valid && rsp_ready && state != S_DONE) rsp_valid <= 1'b0;
      if (cfg_we && cfg_index == fpba_pkg::REG_FIT_POLICY) policy <= cfg_data[1:0];
      if (cfg_we && cfg_index == fpba_pkg::REG_REGION) count <= NW'(1);
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op_q <= req.opcode;
            size_q <= (fpba_pkg::SIZE_W'(req.request_size) + 17'd3) & ~17'd3;
            zero_q <= req.request_size == 16'd0;
            addr_q <= req.payload_address;
            cnt <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          cnt <= cnt + IW'(1);
          if (cnt == IW'(M - 1)) state <= S_DECIDE;
        end
        S_DECIDE: begin
          res_q.granted_address <= '0;
          state <= S_DONE;
          if (op_q == fpba_pkg::OP_ALLOC) begin
            if (zero_q || policy == fpba_pkg::POL_NONE || !sc_found[M-1]) begin
              res_q.status <= fpba_pkg::ST_NOFIT;
            end else if (split && count == NW'(M)) begin
              res_q.status <= fpba_pkg::ST_FULL;
            end else begin
              res_q.status <= fpba_pkg::ST_OK;
              res_q.granted_address <=
                16'(CW'(sc_start[M-1]) + CW'(HEADER_BYTES));
              ctl.op <= fpba_pkg::CMD_ALLOC;
              ctl.split <= split;
              ctl.merge <= 1'b0;
              ctl.clr <= 1'b0;
              cmd_idx <= sc_idx[M-1];
              if (split) count <= count + NW'(1);
              state <= S_APPLY;
            end
          end else begin
            if (!sc_found[M-1] || !sc_busy[M-1]) begin
              res_q.status <= fpba_pkg::ST_BADFREE;
            end else begin
              res_q.status <= fpba_pkg::ST_OK;
              ctl.op <= fpba_pkg::CMD_MERGE;
              ctl.split <= 1'b0;
              ctl.merge <= sc_next[M-1];
              ctl.clr <= 1'b1;
              cmd_idx <= sc_idx[M-1];
              pend_prev <= sc_prev[M-1];
              if (sc_next[M-1]) count <= count - NW'(1);
              state <= S_APPLY;
            end
          end
        end
        S_APPLY: begin
          if (pend_prev) begin
            ctl.op <= fpba_pkg::CMD_MERGE;
            ctl.merge <= 1'b1;
            ctl.clr <= 1'b0;
            cmd_idx <= cmd_idx - IW'(1);
            count <= count - NW'(1);
            pend_prev <= 1'b0;
          end else begin
            ctl.op <= fpba_pkg::CMD_NOP;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp <= res_q;
            rsp_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### design/fpba_cell.sv
module fpba_cell #(
  parameter int AW = 16,
  parameter int IW = 6,
  parameter int HB = 8,
  parameter int K = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      init,
  input  logic [AW-1:0]             init_pay,
  input  fpba_pkg::cell_ctl_t       ctl,
  input  logic [IW-1:0]             cmd_idx,
  input  logic [fpba_pkg::SIZE_W-1:0] size,
  input  logic                      scan_free,
  input  logic [1:0]                policy,
  input  logic [15:0]               addr,
  input  logic                      lft_valid,
  input  logic                      lft_busy,
  input  logic [AW-1:0]             lft_start,
  input  logic [AW-1:0]             lft_pay,
  input  logic                      rgt_valid,
  input  logic                      rgt_busy,
  input  logic [AW-1:0]             rgt_start,
  input  logic [AW-1:0]             rgt_pay,
  output logic                      valid,
  output logic                      busy,
  output logic [AW-1:0]             start,
  output logic [AW-1:0]             pay,
  input  logic                      si_found,
  input  logic [IW-1:0]             si_idx,
  input  logic [AW-1:0]             si_pay,
  input  logic [AW-1:0]             si_start,
  input  logic                      si_busy,
  input  logic                      si_prev,
  input  logic                      si_next,
  output logic                      so_found,
  output logic [IW-1:0]             so_idx,
  output logic [AW-1:0]             so_pay,
  output logic [AW-1:0]             so_start,
  output logic                      so_busy,
  output logic                      so_prev,
  output logic                      so_next
);

  localparam int CW = (AW > 17 ? AW : 17) + 1;
  localparam logic [IW:0] KV = (IW+1)'(K);

  logic [IW:0] idx_w;
  logic        is_me;
  logic        is_next;
  logic        after_next;
  logic        after;
  logic        fits;
  logic        hit;
  logic        elig;
  logic        take;
  logic [CW-1:0] new_start;
  logic [CW-1:0] new_pay;
  logic [CW-1:0] merged_pay;

  assign idx_w = (IW+1)'(cmd_idx);
  assign is_me = idx_w == KV;
  assign is_next = idx_w + (IW+1)'(1) == KV;
  assign after_next = KV > idx_w + (IW+1)'(1);
  assign after = KV > idx_w;
  assign new_start = CW'(lft_start) + CW'(HB) + CW'(size);
  assign new_pay = CW'(lft_pay) - CW'(size) - CW'(HB);
  assign merged_pay = CW'(pay) + CW'(HB) + CW'(rgt_pay);

  always_ff @(posedge clk) begin
    if (init) begin
      valid <= (K == 0);
      busy <= 1'b0;
      start <= '0;
      pay <= (K == 0) ? init_pay : '0;
    end else begin
      case (ctl.op)
        fpba_pkg::CMD_ALLOC: begin
          if (is_me) begin
            busy <= 1'b1;
            if (ctl.split) pay <= AW'(size);
          end else if (ctl.split && is_next) begin
            valid <= 1'b1;
            busy <= 1'b0;
            start <= AW'(new_start);
            pay <= AW'(new_pay);
          end else if (ctl.split && after_next) begin
            valid <= lft_valid;
            busy <= lft_busy;
            start <= lft_start;
            pay <= lft_pay;
          end
        end
        fpba_pkg::CMD_MERGE: begin
          if (is_me) begin
            if (ctl.clr) busy <= 1'b0;
            if (ctl.merge) pay <= AW'(merged_pay);
          end else if (ctl.merge && after) begin
            valid <= rgt_valid;
            busy <= rgt_busy;
            start <= rgt_start;
            pay <= rgt_pay;
          end
        end
        default: ;
      endcase
    end
  end

  // search stage, one cell per cycle
  assign fits = CW'(pay) >= CW'(size);
  assign hit = CW'(start) + CW'(HB) == CW'(addr);
  assign elig = scan_free ? (valid && hit) : (valid && !busy && fits);
  assign take = elig && (!si_found || (!scan_free &&
                ((policy == fpba_pkg::POL_BEST && pay < si_pay) ||
                 (policy == fpba_pkg::POL_WORST && pay > si_pay))));

  always_ff @(posedge clk) begin
    if (rst) begin
      so_found <= 1'b0;
    end else begin
      so_found <= si_found || elig;
    end
    if (take) begin
      so_idx <= IW'(K);
      so_pay <= pay;
      so_start <= start;
      so_busy <= busy;
      so_prev <= lft_valid && !lft_busy;
      so_next <= rgt_valid && !rgt_busy;
    end else begin
      so_idx <= si_idx;
      so_pay <= si_pay;
      so_start <= si_start;
      so_busy <= si_busy;
      so_prev <= si_prev;
      so_next <= si_next;
    end
  end

endmodule
